// ===== hw/rtl/line_loss_recovery_sequencer_top_assert.svh =====
// Assertion macros of the line-loss recovery sequencer top level.
`ifndef LINE_LOSS_RECOVERY_SEQUENCER_TOP_ASSERT_SVH
`define LINE_LOSS_RECOVERY_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LLRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llrs assertion failed");

// Next-cycle implication, disabled during reset.
`define LLRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llrs assertion failed");

`endif

// ===== hw/rtl/llrs_pkg.sv =====
// Types, codes and constants of the line-loss recovery sequencer.
`default_nettype none

package llrs_pkg;

  // Input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Phase codes
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PIVOT1  = 3'd1,
    PH_REVERSE = 3'd2,
    PH_PIVOT2  = 3'd3,
    PH_VERIFY  = 3'd4,
    PH_TIMEOUT = 3'd5
  } phase_e;

  // Motor command codes
  typedef enum logic [2:0] {
    CMD_STOP     = 3'd0,
    CMD_FORWARD  = 3'd1,
    CMD_BACKWARD = 3'd2,
    CMD_LEFT     = 3'd3,
    CMD_RIGHT    = 3'd4
  } cmd_e;

  // Configuration port widths and register indexes
  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] REG_REACQUIRE_NEEDED = 4'd0;
  localparam logic [CfgIndexW-1:0] REG_MAX_TOTAL_TICKS  = 4'd1;
  localparam logic [CfgIndexW-1:0] REG_SWEEP_TICKS      = 4'd2;
  localparam logic [CfgIndexW-1:0] REG_REVERSE_TICKS    = 4'd3;
  localparam logic [CfgIndexW-1:0] REG_VERIFY_TICKS     = 4'd4;
  localparam logic [CfgIndexW-1:0] REG_EXIT_BAND        = 4'd5;
  localparam logic [CfgIndexW-1:0] REG_PIVOT_DUTY       = 4'd6;
  localparam logic [CfgIndexW-1:0] REG_SLOW_DUTY        = 4'd7;

  // Saturation limits
  localparam logic [7:0]  STREAK_MAX = 8'hFF;
  localparam logic [15:0] TOTAL_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  reacquire_needed;
    logic [15:0] max_total_ticks;
    logic [15:0] sweep_ticks;
    logic [15:0] reverse_ticks;
    logic [15:0] verify_ticks;
    logic [14:0] exit_band;
    logic [7:0]  pivot_duty;
    logic [7:0]  slow_duty;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic               side_left;
    logic [3:0]         sensors_on_line;
    logic signed [15:0] line_error;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  motor_command;
    logic [7:0]  left_duty;
    logic [7:0]  right_duty;
    logic [15:0] elapsed_ticks;
    logic        finished;
    logic        found_line;
    logic        gave_up;
  } out_item_t;

  typedef struct packed {
    phase_e      phase;
    logic        primary_is_left;
    logic [15:0] phase_ticks;
    logic [15:0] total_ticks;
    logic [7:0]  hit_streak;
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/llrs_if.sv =====
// Handshake channels of the line-loss recovery sequencer.
`default_nettype none

interface llrs_in_if;
  logic               valid;
  logic               ready;
  llrs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface llrs_out_if;
  logic                valid;
  logic                ready;
  llrs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface llrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [llrs_pkg::CfgIndexW-1:0] index;
  logic [llrs_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/llrs_cfg_regs.sv =====
// Configuration register file of the line-loss recovery sequencer.
`default_nettype none

module llrs_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  llrs_cfg_if.sink           cfg_wr,
  output llrs_pkg::cfg_t     cfg
);

  // Always take writes
  assign cfg_wr.ready = 1'b1;

  // Decode the index and load the register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reacquire_needed <= 8'd3;
      cfg.max_total_ticks  <= 16'd200;
      cfg.sweep_ticks      <= 16'd20;
      cfg.reverse_ticks    <= 16'd10;
      cfg.verify_ticks     <= 16'd20;
      cfg.exit_band        <= 15'd1500;
      cfg.pivot_duty       <= 8'd120;
      cfg.slow_duty        <= 8'd80;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        llrs_pkg::REG_REACQUIRE_NEEDED: cfg.reacquire_needed <= cfg_wr.data[7:0];
        llrs_pkg::REG_MAX_TOTAL_TICKS:  cfg.max_total_ticks  <= cfg_wr.data;
        llrs_pkg::REG_SWEEP_TICKS:      cfg.sweep_ticks      <= cfg_wr.data;
        llrs_pkg::REG_REVERSE_TICKS:    cfg.reverse_ticks    <= cfg_wr.data;
        llrs_pkg::REG_VERIFY_TICKS:     cfg.verify_ticks     <= cfg_wr.data;
        llrs_pkg::REG_EXIT_BAND:        cfg.exit_band        <= cfg_wr.data[14:0];
        llrs_pkg::REG_PIVOT_DUTY:       cfg.pivot_duty       <= cfg_wr.data[7:0];
        llrs_pkg::REG_SLOW_DUTY:        cfg.slow_duty        <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/llrs_step.sv =====
// Single-item step logic: next sequencer state and result for one item.
`default_nettype none

module llrs_step (
  input  wire llrs_pkg::state_t    st,
  input  wire llrs_pkg::cfg_t      cfg,
  input  wire llrs_pkg::in_item_t  item,
  output llrs_pkg::state_t    st_next,
  output llrs_pkg::out_item_t res,
  output logic                has_res
);

  logic [16:0]      err_ext;
  logic [16:0]      err_abs;
  logic             hit;
  logic [7:0]       streak_new;
  logic             reacq;
  logic             tmo;
  logic             active;
  llrs_pkg::cmd_e   act_cmd;
  logic [7:0]       act_duty;
  logic [15:0]      act_limit;
  llrs_pkg::phase_e act_next;
  logic [15:0]      pt_inc;
  logic             advance;
  logic [15:0]      total_inc;

  // Reacquire hit: some sensor on the line and |error| inside the band
  assign err_ext = {item.line_error[15], item.line_error};
  assign err_abs = item.line_error[15] ? (17'd0 - err_ext) : err_ext;
  assign hit     = (item.sensors_on_line != 4'd0) && (err_abs < {2'b00, cfg.exit_band});

  // Saturating hit streak and the end checks
  assign streak_new = !hit ? 8'd0 :
                      (st.hit_streak == llrs_pkg::STREAK_MAX) ? st.hit_streak :
                      st.hit_streak + 8'd1;
  assign reacq = streak_new >= cfg.reacquire_needed;
  assign tmo   = st.total_ticks >= cfg.max_total_ticks;

  // Command, duty, length and successor of the current phase
  always_comb begin
    act_cmd   = llrs_pkg::CMD_STOP;
    act_duty  = 8'd0;
    act_limit = 16'd0;
    act_next  = llrs_pkg::PH_TIMEOUT;
    active    = 1'b1;
    unique case (st.phase)
      llrs_pkg::PH_PIVOT1: begin
        act_cmd   = st.primary_is_left ? llrs_pkg::CMD_LEFT : llrs_pkg::CMD_RIGHT;
        act_duty  = cfg.pivot_duty;
        act_limit = cfg.sweep_ticks;
        act_next  = llrs_pkg::PH_REVERSE;
      end
      llrs_pkg::PH_REVERSE: begin
        act_cmd   = llrs_pkg::CMD_BACKWARD;
        act_duty  = cfg.slow_duty;
        act_limit = cfg.reverse_ticks;
        act_next  = llrs_pkg::PH_PIVOT2;
      end
      llrs_pkg::PH_PIVOT2: begin
        act_cmd   = st.primary_is_left ? llrs_pkg::CMD_RIGHT : llrs_pkg::CMD_LEFT;
        act_duty  = cfg.pivot_duty;
        act_limit = cfg.sweep_ticks;
        act_next  = llrs_pkg::PH_VERIFY;
      end
      llrs_pkg::PH_VERIFY: begin
        act_cmd   = llrs_pkg::CMD_FORWARD;
        act_duty  = cfg.slow_duty;
        act_limit = cfg.verify_ticks;
        act_next  = llrs_pkg::PH_TIMEOUT;
      end
      default: active = 1'b0;
    endcase
  end

  // Phase tick count and saturating total; a length of zero ends after one tick
  assign pt_inc    = st.phase_ticks + 16'd1;
  assign advance   = pt_inc >= act_limit;
  assign total_inc = (st.total_ticks == llrs_pkg::TOTAL_MAX) ? st.total_ticks :
                     st.total_ticks + 16'd1;

  // Select next state and result
  always_comb begin
    st_next           = st;
    has_res           = 1'b0;
    res.phase         = llrs_pkg::PH_IDLE;
    res.motor_command = llrs_pkg::CMD_STOP;
    res.left_duty     = 8'd0;
    res.right_duty    = 8'd0;
    res.elapsed_ticks = st.total_ticks;
    res.finished      = 1'b1;
    res.found_line    = 1'b0;
    res.gave_up       = 1'b0;
    if (item.op == llrs_pkg::OP_START) begin
      // Arm a new recovery
      st_next.primary_is_left = item.side_left;
      st_next.phase           = llrs_pkg::PH_PIVOT1;
      st_next.phase_ticks     = 16'd0;
      st_next.total_ticks     = 16'd0;
      st_next.hit_streak      = 8'd0;
    end else begin
      has_res = 1'b1;
      if (st.phase != llrs_pkg::PH_IDLE) begin
        st_next.hit_streak = streak_new;
        if (reacq) begin
          st_next.phase  = llrs_pkg::PH_IDLE;
          res.found_line = 1'b1;
        end else if (tmo || !active) begin
          st_next.phase = llrs_pkg::PH_TIMEOUT;
          res.phase     = llrs_pkg::PH_TIMEOUT;
          res.gave_up   = 1'b1;
        end else if (advance && (act_next == llrs_pkg::PH_TIMEOUT)) begin
          // Verify over: stop without advancing the total
          st_next.phase       = llrs_pkg::PH_TIMEOUT;
          st_next.phase_ticks = 16'd0;
          res.phase           = llrs_pkg::PH_TIMEOUT;
          res.gave_up         = 1'b1;
        end else begin
          st_next.phase       = advance ? act_next : st.phase;
          st_next.phase_ticks = advance ? 16'd0 : pt_inc;
          st_next.total_ticks = total_inc;
          res.phase           = advance ? act_next : st.phase;
          res.motor_command   = act_cmd;
          res.left_duty       = act_duty;
          res.right_duty      = act_duty;
          res.elapsed_ticks   = total_inc;
          res.finished        = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_loss_recovery_sequencer_top.sv =====
// Top level of the line-loss recovery sequencer.
//
//   channel     dir  handshake      payload
//   item_in     in   valid/ready    op, side_left, sensors_on_line, line_error
//   result_out  out  valid/ready    phase, motor_command, duties, elapsed, flags
//   cfg_wr      in   valid/ready    index, data (always ready)
//
// An item is held in the input register, then stepped into the result
// register once the result register is empty or being taken.
// Throughput: one item per cycle while the result is not stalled, set by
// the single step through llrs_step.
// Start items update the state and produce no result, even while the result
// register is stalled. A stalled result holds the input register; ready
// falls only when both are full. Reset (rst, synchronous) clears both valid
// flags and the sequencer state to idle; configuration returns to defaults.
`default_nettype none

module line_loss_recovery_sequencer_top (
  input  wire logic  clk,
  input  wire logic  rst,
  llrs_in_if.sink    item_in,
  llrs_out_if.source result_out,
  llrs_cfg_if.sink   cfg_wr
);

`include "line_loss_recovery_sequencer_top_assert.svh"

  llrs_pkg::cfg_t      cfg;
  llrs_pkg::state_t    st;
  llrs_pkg::state_t    st_next;
  llrs_pkg::in_item_t  in_item;
  logic                in_valid;
  llrs_pkg::out_item_t res;
  logic                has_res;
  llrs_pkg::out_item_t out_item;
  logic                out_valid;
  logic                proceed;

  llrs_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  llrs_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_item),
    .st_next (st_next),
    .res     (res),
    .has_res (has_res)
  );

  // Step the held item when it needs no result slot or the slot frees up
  assign proceed = in_valid &&
                   ((in_item.op == llrs_pkg::OP_START) || !out_valid || result_out.ready);
  assign item_in.ready = !in_valid || proceed;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      in_item <= item_in.data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= llrs_pkg::PH_IDLE;
      st.primary_is_left <= 1'b0;
      st.phase_ticks     <= 16'd0;
      st.total_ticks     <= 16'd0;
      st.hit_streak      <= 8'd0;
    end else if (proceed) begin
      st <= st_next;
    end
  end

  // Result register: load on a stepped tick, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && has_res) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && has_res) begin
      out_item <= res;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.data  = out_item;

  // A running result always shows one of the four active phases
  `LLRS_ASSERT_NOW(a_running_phase, clk, rst, out_valid && !out_item.finished,
    (out_item.phase == llrs_pkg::PH_PIVOT1) || (out_item.phase == llrs_pkg::PH_REVERSE) ||
    (out_item.phase == llrs_pkg::PH_PIVOT2) || (out_item.phase == llrs_pkg::PH_VERIFY))
  // A recovery never ends both found and given up
  `LLRS_ASSERT_NOW(a_end_flags, clk, rst, out_valid,
    !(out_item.found_line && out_item.gave_up))
  // A start item arms pivot primary with cleared counters
  `LLRS_ASSERT_NEXT(a_start_arms, clk, rst, proceed && (in_item.op == llrs_pkg::OP_START),
    (st.phase == llrs_pkg::PH_PIVOT1) && (st.total_ticks == 16'd0) && (st.hit_streak == 8'd0))
  // Ticks never make the total go backwards
  `LLRS_ASSERT_NEXT(a_total_mono, clk, rst, proceed && (in_item.op == llrs_pkg::OP_TICK),
    st.total_ticks >= $past(st.total_ticks))

endmodule

`default_nettype wire
